// ===== rtl/cbse_pkg.sv =====
`default_nettype none

package cbse_pkg;

   localparam int MAX_POINTS = 1024;
   localparam int PTR_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = PTR_W;
   localparam int FRAC_BITS  = 16;
   localparam int MU_W       = FRAC_BITS + 1;
   localparam int COORD_W    = 32;
   localparam int SEG_W      = PTR_W + 1;

   // reflected neighbors need two more bits, Horner partial sums six more
   localparam int EXT_W      = COORD_W + 2;
   localparam int ACC_W      = COORD_W + 6;

   // mu * h is split into two half products
   localparam int LO_W       = ACC_W / 2;
   localparam int HI_W       = ACC_W - LO_W;
   localparam int LO_PROD_W  = FRAC_BITS + LO_W;
   localparam int HI_PROD_W  = MU_W + HI_W;
   localparam int PROD_W     = HI_PROD_W + LO_W;

   // divide by six: bias to non-negative, halve, then radix-4 divide by three
   localparam int Y_W        = ACC_W + 1;
   localparam int DIV_CHUNK  = 12;
   localparam int DIV_DIGITS = DIV_CHUNK / 2;
   localparam int DIV_STEPS  = 3;
   localparam int DIV_W      = DIV_CHUNK * DIV_STEPS;

   localparam logic [CNT_W-1:0] NUM_SEG_RESET = CNT_W'(1);

   localparam logic [1:0] STEP_C2 = 2'd0;
   localparam logic [1:0] STEP_C1 = 2'd1;
   localparam logic [1:0] STEP_C0 = 2'd2;

   typedef enum logic [2:0] {
      DST_NONE,
      DST_P0,
      DST_P1,
      DST_E0,
      DST_E1
   } dst_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
   } point_type;

   typedef struct packed {
      dst_type              cap;
      logic                 refl;
      logic                 coef;
      logic                 mul;
      logic                 acc;
      logic [1:0]           step;
      logic                 divp;
      logic                 div;
      logic                 first;
      logic                 last;
      logic                 direct;
      logic [FRAC_BITS-1:0] mu;
   } lane_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/cbse_point_ram.sv =====
`default_nettype none

module cbse_point_ram (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [cbse_pkg::PTR_W-1:0]     wr_addr,
   input  cbse_pkg::point_type            wr_data,
   input  logic                           rd_en,
   input  logic [cbse_pkg::PTR_W-1:0]     rd_addr,
   output cbse_pkg::point_type            rd_data
);
   import cbse_pkg::*;

   point_type point_mem [MAX_POINTS];
   point_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         point_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= point_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/cbse_lane.sv =====
`default_nettype none

module cbse_lane (
   input  logic                                clock,
   input  cbse_pkg::lane_ctrl_type             ctrl,
   input  logic signed [cbse_pkg::COORD_W-1:0] rd_coord,
   output logic signed [cbse_pkg::COORD_W-1:0] result
);
   import cbse_pkg::*;

   localparam longint DIV_BIAS = 64'sd6 * (64'sd1 <<< (COORD_W - 1)) + 64'sd3;
   localparam longint SAT_LIM  = 64'sd12 * (64'sd1 <<< (COORD_W - 1));
   localparam logic signed [COORD_W-1:0] SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] SAT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   function automatic logic [DIV_CHUNK+1:0] div3_chunk(input logic [1:0] rem_i,
                                                        input logic [DIV_CHUNK-1:0] bits);
      logic [1:0]           r;
      logic [3:0]           v;
      logic [1:0]           qd;
      logic [DIV_CHUNK-1:0] q;
      r = rem_i;
      q = '0;
      for (int i = 0; i < DIV_DIGITS; i++) begin
         v = {r, bits[DIV_CHUNK-1-2*i -: 2]};
         if (v >= 4'd9) begin
            qd = 2'd3;
         end else if (v >= 4'd6) begin
            qd = 2'd2;
         end else if (v >= 4'd3) begin
            qd = 2'd1;
         end else begin
            qd = 2'd0;
         end
         r = 2'(v - {2'b00, qd} * 4'd3);
         q[DIV_CHUNK-1-2*i -: 2] = qd;
      end
      return {q, r};
   endfunction

   logic signed [COORD_W-1:0]   p0_ff, p0_in, p1_ff, p1_in;
   logic signed [EXT_W-1:0]     e0_ff, e0_in, e1_ff, e1_in;
   logic signed [ACC_W-1:0]     c0_ff, c0_in, c1_ff, c1_in, c2_ff, c2_in;
   logic signed [ACC_W-1:0]     h_ff, h_in;
   logic [LO_PROD_W-1:0]        lo_ff, lo_in;
   logic signed [HI_PROD_W-1:0] hi_ff, hi_in;
   logic [DIV_W-1:0]            dvd_ff, dvd_in, quot_ff, quot_in;
   logic [1:0]                  rem_ff, rem_in;
   logic                        sat_hi_ff, sat_hi_in, sat_lo_ff, sat_lo_in;

   logic signed [EXT_W-1:0]     cap_ext, p0_ext, p1_ext, refl_e0, refl_e1;
   logic signed [ACC_W-1:0]     we0, wp0, wp1, we1, c3, csel;
   logic signed [MU_W-1:0]      mu_s;
   logic [PROD_W-1:0]           prod;
   logic [Y_W-1:0]              y;
   logic [DIV_CHUNK+1:0]        dstep;
   logic [COORD_W-1:0]          qv;

   assign cap_ext = {{(EXT_W-COORD_W){rd_coord[COORD_W-1]}}, rd_coord};
   assign p0_ext  = {{(EXT_W-COORD_W){p0_ff[COORD_W-1]}}, p0_ff};
   assign p1_ext  = {{(EXT_W-COORD_W){p1_ff[COORD_W-1]}}, p1_ff};
   assign refl_e0 = (p0_ext <<< 1) - p1_ext;
   assign refl_e1 = (p1_ext <<< 1) - p0_ext;

   assign we0 = {{(ACC_W-EXT_W){e0_ff[EXT_W-1]}}, e0_ff};
   assign we1 = {{(ACC_W-EXT_W){e1_ff[EXT_W-1]}}, e1_ff};
   assign wp0 = {{(ACC_W-COORD_W){p0_ff[COORD_W-1]}}, p0_ff};
   assign wp1 = {{(ACC_W-COORD_W){p1_ff[COORD_W-1]}}, p1_ff};
   assign c3  = we1 - we0 + (wp0 <<< 1) + wp0 - (wp1 <<< 1) - wp1;

   assign mu_s = {1'b0, ctrl.mu};
   assign prod = {hi_ff, {LO_W{1'b0}}} + PROD_W'(lo_ff);
   assign y    = {h_ff[ACC_W-1], h_ff} + Y_W'(DIV_BIAS);
   assign dstep = div3_chunk(rem_ff, dvd_ff[DIV_W-1 -: DIV_CHUNK]);
   assign qv   = quot_ff[COORD_W-1:0];

   always_comb begin
      case (ctrl.step)
         STEP_C2: csel = c2_ff;
         STEP_C1: csel = c1_ff;
         default: csel = c0_ff;
      endcase
   end

   always_comb begin
      p0_in     = p0_ff;
      p1_in     = p1_ff;
      e0_in     = e0_ff;
      e1_in     = e1_ff;
      c0_in     = c0_ff;
      c1_in     = c1_ff;
      c2_in     = c2_ff;
      h_in      = h_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      dvd_in    = dvd_ff;
      quot_in   = quot_ff;
      rem_in    = rem_ff;
      sat_hi_in = sat_hi_ff;
      sat_lo_in = sat_lo_ff;

      if (ctrl.cap == DST_P0) begin
         p0_in = rd_coord;
      end
      if (ctrl.cap == DST_P1) begin
         p1_in = rd_coord;
      end
      if (ctrl.cap == DST_E0) begin
         e0_in = cap_ext;
      end else if (ctrl.refl && ctrl.first) begin
         e0_in = refl_e0;
      end
      if (ctrl.cap == DST_E1) begin
         e1_in = cap_ext;
      end else if (ctrl.refl && ctrl.last) begin
         e1_in = refl_e1;
      end

      if (ctrl.coef) begin
         c0_in = we0 + (wp0 <<< 2) + wp1;
         c1_in = (wp1 <<< 1) + wp1 - (we0 <<< 1) - we0;
         c2_in = (we0 <<< 1) + we0 - (wp0 <<< 2) - (wp0 <<< 1) + (wp1 <<< 1) + wp1;
         h_in  = c3;
      end

      if (ctrl.mul) begin
         lo_in = LO_PROD_W'(ctrl.mu) * LO_PROD_W'(h_ff[LO_W-1:0])
               + LO_PROD_W'(1 << (FRAC_BITS - 1));
         hi_in = HI_PROD_W'(mu_s) * HI_PROD_W'($signed(h_ff[ACC_W-1:LO_W]));
      end

      if (ctrl.acc) begin
         h_in = csel + prod[FRAC_BITS+ACC_W-1:FRAC_BITS];
      end

      if (ctrl.divp) begin
         sat_lo_in = y[Y_W-1];
         sat_hi_in = !y[Y_W-1] && (y >= Y_W'(SAT_LIM));
         dvd_in    = DIV_W'(y[COORD_W+2:1]);
         rem_in    = 2'd0;
         quot_in   = '0;
      end

      if (ctrl.div) begin
         dvd_in  = dvd_ff << DIV_CHUNK;
         quot_in = {quot_ff[DIV_W-DIV_CHUNK-1:0], dstep[DIV_CHUNK+1:2]};
         rem_in  = dstep[1:0];
      end
   end

   always_ff @(posedge clock) begin
      p0_ff     <= p0_in;
      p1_ff     <= p1_in;
      e0_ff     <= e0_in;
      e1_ff     <= e1_in;
      c0_ff     <= c0_in;
      c1_ff     <= c1_in;
      c2_ff     <= c2_in;
      h_ff      <= h_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      dvd_ff    <= dvd_in;
      quot_ff   <= quot_in;
      rem_ff    <= rem_in;
      sat_hi_ff <= sat_hi_in;
      sat_lo_ff <= sat_lo_in;
   end

   always_comb begin
      if (ctrl.direct) begin
         result = p0_ff;
      end else if (sat_hi_ff) begin
         result = SAT_MAX;
      end else if (sat_lo_ff) begin
         result = SAT_MIN;
      end else begin
         result = {~qv[COORD_W-1], qv[COORD_W-2:0]};
      end
   end

endmodule

`default_nettype wire

// ===== rtl/cubic_bspline_segment_eval.sv =====
`default_nettype none

// Uniform cubic B-spline evaluator over a 1024-entry store of 3-D control
// points (signed Q15.16). A write word stores one point and leaves the
// block idle. An evaluate word returns the curve point for a segment and a
// local parameter mu (Q1.16), with end neighbors reflected, results rounded
// and saturated. An interior evaluation steps through the accept, four read
// steps on the single-port point memory, a wait for the registered read
// data, a coefficient step, three Horner steps of a multiply and an
// accumulate each, the divide by six and the load of the result. Clamped
// cases (segment out of range, mu at 0 or at least 1) read one stored point
// and return it. The x, y and z lanes run in parallel. The result sits in an
// output register, so the next word is taken while it waits on rsp_stall.
module cubic_bspline_segment_eval (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                csr_wr_en,
   input  logic [cbse_pkg::CNT_W-1:0]          csr_wr_data,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_opcode,
   input  logic [cbse_pkg::PTR_W-1:0]          req_point_index,
   input  logic signed [cbse_pkg::COORD_W-1:0] req_coord_x,
   input  logic signed [cbse_pkg::COORD_W-1:0] req_coord_y,
   input  logic signed [cbse_pkg::COORD_W-1:0] req_coord_z,
   input  logic signed [cbse_pkg::SEG_W-1:0]   req_segment,
   input  logic [cbse_pkg::MU_W-1:0]           req_mu,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [cbse_pkg::COORD_W-1:0] rsp_pos_x,
   output logic signed [cbse_pkg::COORD_W-1:0] rsp_pos_y,
   output logic signed [cbse_pkg::COORD_W-1:0] rsp_pos_z
);
   import cbse_pkg::*;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_EVAL  = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RD_P0,
      S_RD_P1,
      S_RD_E0,
      S_RD_E1,
      S_WAIT,
      S_COEF,
      S_MUL,
      S_ACC,
      S_DIVP,
      S_DIV,
      S_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     num_seg_ff, num_seg_in;
   logic [PTR_W-1:0]     seg_ff, seg_in, daddr_ff, daddr_in;
   logic                 direct_ff, direct_in, first_ff, first_in, last_ff, last_in;
   logic [FRAC_BITS-1:0] mu_ff, mu_in;
   logic [1:0]           step_ff, step_in;
   dst_type              rd_tag_ff, rd_tag_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_W-1:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in, pos_z_ff, pos_z_in;

   logic                 accept;
   logic [CNT_W-1:0]     n_eff;
   logic [PTR_W-1:0]     seg_u, seg_next;
   logic                 seg_neg, past_end, mu_zero, mu_one;

   logic                 ram_wr_en, ram_rd_en;
   logic [PTR_W-1:0]     ram_rd_addr;
   dst_type              rd_tag;
   point_type            wr_point, rd_point;
   lane_ctrl_type        lctrl;
   logic signed [COORD_W-1:0] res_x, res_y, res_z;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign ram_wr_en = accept && (req_opcode == OP_WRITE);
   assign wr_point  = '{x: req_coord_x, y: req_coord_y, z: req_coord_z};

   assign n_eff    = (num_seg_ff == '0) ? CNT_W'(1) : num_seg_ff;
   assign seg_neg  = req_segment[SEG_W-1];
   assign seg_u    = req_segment[PTR_W-1:0];
   assign seg_next = seg_u + PTR_W'(1);
   assign past_end = (seg_u >= n_eff);
   assign mu_zero  = (req_mu == '0);
   assign mu_one   = req_mu[FRAC_BITS];

   always_comb begin
      ram_rd_en   = 1'b0;
      ram_rd_addr = seg_ff;
      rd_tag      = DST_NONE;
      case (state_ff)
         S_RD_P0: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = direct_ff ? daddr_ff : seg_ff;
            rd_tag      = DST_P0;
         end
         S_RD_P1: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = seg_ff + PTR_W'(1);
            rd_tag      = DST_P1;
         end
         S_RD_E0: begin
            ram_rd_en   = !first_ff;
            ram_rd_addr = seg_ff - PTR_W'(1);
            rd_tag      = DST_E0;
         end
         S_RD_E1: begin
            ram_rd_en   = !last_ff;
            ram_rd_addr = seg_ff + PTR_W'(2);
            rd_tag      = DST_E1;
         end
         default: begin
            ram_rd_en = 1'b0;
         end
      endcase
   end

   always_comb begin
      lctrl        = '0;
      lctrl.cap    = rd_tag_ff;
      lctrl.refl   = (state_ff == S_WAIT);
      lctrl.coef   = (state_ff == S_COEF);
      lctrl.mul    = (state_ff == S_MUL);
      lctrl.acc    = (state_ff == S_ACC);
      lctrl.divp   = (state_ff == S_DIVP);
      lctrl.div    = (state_ff == S_DIV);
      lctrl.step   = step_ff;
      lctrl.first  = first_ff;
      lctrl.last   = last_ff;
      lctrl.direct = direct_ff;
      lctrl.mu     = mu_ff;
   end

   always_comb begin
      state_in     = state_ff;
      num_seg_in   = csr_wr_en ? csr_wr_data : num_seg_ff;
      seg_in       = seg_ff;
      daddr_in     = daddr_ff;
      direct_in    = direct_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      mu_in        = mu_ff;
      step_in      = step_ff;
      rd_tag_in    = ram_rd_en ? rd_tag : DST_NONE;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      pos_z_in     = pos_z_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept && (req_opcode == OP_EVAL)) begin
               seg_in    = seg_u;
               direct_in = seg_neg || past_end || mu_zero || mu_one;
               first_in  = (seg_u == '0);
               last_in   = (seg_next == n_eff);
               mu_in     = req_mu[FRAC_BITS-1:0];
               if (seg_neg) begin
                  daddr_in = '0;
               end else if (past_end) begin
                  daddr_in = n_eff;
               end else if (mu_zero) begin
                  daddr_in = seg_u;
               end else begin
                  daddr_in = seg_next;
               end
               state_in = S_RD_P0;
            end
         end
         S_RD_P0: state_in = direct_ff ? S_WAIT : S_RD_P1;
         S_RD_P1: state_in = S_RD_E0;
         S_RD_E0: state_in = S_RD_E1;
         S_RD_E1: state_in = S_WAIT;
         S_WAIT:  state_in = direct_ff ? S_DONE : S_COEF;
         S_COEF: begin
            step_in  = STEP_C2;
            state_in = S_MUL;
         end
         S_MUL: state_in = S_ACC;
         S_ACC: begin
            if (step_ff == STEP_C0) begin
               state_in = S_DIVP;
            end else begin
               step_in  = step_ff + 2'd1;
               state_in = S_MUL;
            end
         end
         S_DIVP: begin
            step_in  = 2'd0;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (step_ff == 2'(DIV_STEPS - 1)) begin
               state_in = S_DONE;
            end else begin
               step_in = step_ff + 2'd1;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               pos_x_in     = res_x;
               pos_y_in     = res_y;
               pos_z_in     = res_z;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         num_seg_ff   <= NUM_SEG_RESET;
         rd_tag_ff    <= DST_NONE;
         rsp_valid_ff <= 1'b0;
         step_ff      <= 2'd0;
         direct_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         num_seg_ff   <= num_seg_in;
         rd_tag_ff    <= rd_tag_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         direct_ff    <= direct_in;
      end
      seg_ff   <= seg_in;
      daddr_ff <= daddr_in;
      first_ff <= first_in;
      last_ff  <= last_in;
      mu_ff    <= mu_in;
      pos_x_ff <= pos_x_in;
      pos_y_ff <= pos_y_in;
      pos_z_ff <= pos_z_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pos_x = pos_x_ff;
   assign rsp_pos_y = pos_y_ff;
   assign rsp_pos_z = pos_z_ff;

   cbse_point_ram point_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (req_point_index),
      .wr_data (wr_point),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (rd_point)
   );

   cbse_lane lane_x (
      .clock    (clock),
      .ctrl     (lctrl),
      .rd_coord (rd_point.x),
      .result   (res_x)
   );

   cbse_lane lane_y (
      .clock    (clock),
      .ctrl     (lctrl),
      .rd_coord (rd_point.y),
      .result   (res_y)
   );

   cbse_lane lane_z (
      .clock    (clock),
      .ctrl     (lctrl),
      .rd_coord (rd_point.z),
      .result   (res_z)
   );

   a_wr_only_idle: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == S_IDLE))
      else $error("point write during evaluation");

   a_tag_after_read: assert property (@(posedge clock) disable iff (reset)
      (rd_tag_ff != DST_NONE) |-> $past(ram_rd_en))
      else $error("capture without a memory read");

   a_eval_starts_read: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_opcode == OP_EVAL)) |=> (ram_rd_en && (state_ff == S_RD_P0)))
      else $error("evaluate word did not start reads");

   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DONE) && !(rsp_valid_ff && rsp_stall))
      |=> (rsp_valid_ff && (state_ff == S_IDLE)))
      else $error("result not loaded on completion");

endmodule

`default_nettype wire

// ===== tb/sv/cubic_bspline_segment_eval_test.sv =====
`timescale 1ns / 1ps

module cubic_bspline_segment_eval_test;
   import cbse_pkg::*;

   localparam logic OP_WRITE      = 1'b0;
   localparam logic OP_EVAL       = 1'b1;
   localparam int   MU_ONE        = 1 << FRAC_BITS;
   localparam int   SETTLE_CYCLES = 40;
   localparam int   DIR_ROWS      = 22;
   localparam longint HALF_LSB    = longint'(1) << (FRAC_BITS - 1);
   localparam longint COORD_MAX   = 64'sd2147483647;
   localparam longint COORD_MIN   = -64'sd2147483648;

   localparam point_type PT_ZERO = '{32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000};
   localparam point_type PT_A    = '{32'sh0001_0000, 32'shFFFF_0000, 32'sh0000_8000};
   localparam point_type PT_B    = '{32'sh0003_0000, 32'sh0002_4000, 32'shFFFE_0000};
   localparam point_type PT_HI   = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF};
   localparam point_type PT_LO   = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000};
   localparam point_type PT_C    = '{32'sh0005_0000, 32'shFFFB_8000, 32'sh0000_0001};

   typedef struct {
      logic      op;
      int        idx;
      point_type pt;
      int        seg;
      int        mu;
      bit        typed;
      point_type want;
   } stim_row_type;

   logic                        clock;
   logic                        reset           = 1'b1;
   logic                        csr_wr_en       = 1'b0;
   logic [CNT_W-1:0]            csr_wr_data     = '0;
   logic                        req_valid       = 1'b0;
   logic                        req_stall;
   logic                        req_opcode      = OP_WRITE;
   logic [PTR_W-1:0]            req_point_index = '0;
   logic signed [COORD_W-1:0]   req_coord_x     = '0;
   logic signed [COORD_W-1:0]   req_coord_y     = '0;
   logic signed [COORD_W-1:0]   req_coord_z     = '0;
   logic signed [SEG_W-1:0]     req_segment     = '0;
   logic [MU_W-1:0]             req_mu          = '0;
   logic                        rsp_valid;
   logic                        rsp_stall       = 1'b0;
   logic signed [COORD_W-1:0]   rsp_pos_x;
   logic signed [COORD_W-1:0]   rsp_pos_y;
   logic signed [COORD_W-1:0]   rsp_pos_z;

   logic signed [COORD_W-1:0]   ctrl_pts [MAX_POINTS][3];
   bit                          written [MAX_POINTS];
   int                          num_seg = 1;
   point_type                   due_points [$];
   stim_row_type                dir_rows [DIR_ROWS];
   int                          mismatches = 0;
   int                          send_idle_pct = 0;
   int                          rsp_stall_pct = 0;
   int                          win_lo = 0;
   int                          win_hi = 1;

   cubic_bspline_segment_eval uut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_point_index (req_point_index),
      .req_coord_x     (req_coord_x),
      .req_coord_y     (req_coord_y),
      .req_coord_z     (req_coord_z),
      .req_segment     (req_segment),
      .req_mu          (req_mu),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pos_x       (rsp_pos_x),
      .rsp_pos_y       (rsp_pos_y),
      .rsp_pos_z       (rsp_pos_z)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

   // mu * h in Q0.16, rounded to nearest with ties up
   function automatic longint mu_scale(input int mu, input longint h);
      return (mu * h + HALF_LSB) >>> FRAC_BITS;
   endfunction

   function automatic point_type curve_point(input int seg, input int mu);
      int        cnt;
      int        k;
      longint    p0, p1, e0, e1, c0, c1, c2, c3, h, q;
      longint    lane [3];
      point_type res;
      cnt = (num_seg == 0) ? 1 : num_seg;
      if (cnt > MAX_POINTS - 1) cnt = MAX_POINTS - 1;
      for (k = 0; k < 3; k++) begin
         if (seg < 0) begin
            lane[k] = ctrl_pts[0][k];
         end else if (seg >= cnt) begin
            lane[k] = ctrl_pts[cnt][k];
         end else if (mu == 0) begin
            lane[k] = ctrl_pts[seg][k];
         end else if (mu >= MU_ONE) begin
            lane[k] = ctrl_pts[seg + 1][k];
         end else begin
            p0 = ctrl_pts[seg][k];
            p1 = ctrl_pts[seg + 1][k];
            e0 = (seg == 0) ? 2 * p0 - p1 : longint'(ctrl_pts[seg - 1][k]);
            e1 = (seg + 1 == cnt) ? 2 * p1 - p0 : longint'(ctrl_pts[seg + 2][k]);
            c0 = e0 + 4 * p0 + p1;
            c1 = 3 * (p1 - e0);
            c2 = 3 * (e0 - 2 * p0 + p1);
            c3 = 3 * (p0 - p1) + e1 - e0;
            h = c2 + mu_scale(mu, c3);
            h = c1 + mu_scale(mu, h);
            h = c0 + mu_scale(mu, h);
            // floor((h + 3) / 6)
            q = (h + 3) / 6;
            if (h + 3 < 0 && (h + 3) % 6 != 0) q = q - 1;
            if (q > COORD_MAX) q = COORD_MAX;
            if (q < COORD_MIN) q = COORD_MIN;
            lane[k] = q;
         end
      end
      res.x = COORD_W'(lane[0]);
      res.y = COORD_W'(lane[1]);
      res.z = COORD_W'(lane[2]);
      return res;
   endfunction

   function automatic logic signed [COORD_W-1:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2, 3: return int'($urandom_range(0, 2097152)) - 1048576;
         default: return $urandom;
      endcase
   endfunction

   // evaluations that would touch an unwritten point become writes of that point
   function automatic stim_row_type random_row(input int cnt);
      stim_row_type row;
      int        pick;
      int        need_lo;
      int        need_hi;
      int        miss;
      int        i;
      row.typed = 1'b0;
      row.want  = PT_ZERO;
      row.pt    = '{rand_coord(), rand_coord(), rand_coord()};
      row.idx   = 0;
      row.seg   = 0;
      row.mu    = 0;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         row.op = OP_WRITE;
         pick = $urandom_range(0, 99);
         if (pick < 50) begin
            row.idx = $urandom_range((win_lo > 0) ? win_lo - 1 : 0,
                                     (win_hi + 1 < MAX_POINTS) ? win_hi + 1 : MAX_POINTS - 1);
         end else if (pick < 70) begin
            row.idx = (pick < 60) ? 0 : cnt;
         end else begin
            row.idx = $urandom_range(0, MAX_POINTS - 1);
         end
         return row;
      end
      row.op = OP_EVAL;
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         row.seg = -int'($urandom_range(1, 1024));
         need_lo = 0;
         need_hi = 0;
      end else if (pick < 20) begin
         row.seg = $urandom_range(cnt, 1023);
         need_lo = cnt;
         need_hi = cnt;
      end else begin
         row.seg = $urandom_range(win_lo, win_hi - 1);
         need_lo = (row.seg > 0) ? row.seg - 1 : 0;
         need_hi = (row.seg + 2 < cnt) ? row.seg + 2 : cnt;
      end
      pick = $urandom_range(0, 99);
      if (pick < 10) row.mu = 0;
      else if (pick < 20) row.mu = $urandom_range(MU_ONE, (1 << MU_W) - 1);
      else if (pick < 25) row.mu = (pick < 23) ? 1 : MU_ONE - 1;
      else row.mu = $urandom_range(1, MU_ONE - 1);
      miss = -1;
      for (i = need_hi; i >= need_lo; i--) begin
         if (!written[i]) miss = i;
      end
      if (miss >= 0) begin
         row.op  = OP_WRITE;
         row.idx = miss;
      end
      return row;
   endfunction

   task automatic send_word(input stim_row_type row);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= row.op;
      req_point_index <= PTR_W'(row.idx);
      req_coord_x     <= row.pt.x;
      req_coord_y     <= row.pt.y;
      req_coord_z     <= row.pt.z;
      req_segment     <= SEG_W'(row.seg);
      req_mu          <= MU_W'(row.mu);
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (row.op == OP_WRITE) begin
         ctrl_pts[row.idx][0] = row.pt.x;
         ctrl_pts[row.idx][1] = row.pt.y;
         ctrl_pts[row.idx][2] = row.pt.z;
         written[row.idx] = 1'b1;
      end else if (row.typed) begin
         due_points.push_back(row.want);
      end else begin
         due_points.push_back(curve_point(row.seg, row.mu));
      end
   endtask

   // only while idle: all results in, then settle for in-flight writes
   task automatic set_segments(input int value);
      req_valid <= 1'b0;
      while (due_points.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= CNT_W'(value);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      num_seg = value;
   endtask

   task automatic run_phase(input int segs, input int send_pct, input int stall_pct,
                            input int words);
      int cnt;
      set_segments(segs);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      cnt = (segs == 0) ? 1 : segs;
      win_lo = $urandom_range(0, (cnt > 8) ? cnt - 8 : 0);
      win_hi = (win_lo + 8 < cnt) ? win_lo + 8 : cnt;
      repeat (words) send_word(random_row(cnt));
   endtask

   always @(posedge clock) begin
      point_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_points.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected word: %h %h %h", rsp_pos_x, rsp_pos_y, rsp_pos_z);
            mismatches++;
         end else begin
            want = due_points.pop_front();
            if (rsp_pos_x !== want.x || rsp_pos_y !== want.y || rsp_pos_z !== want.z) begin
               if (mismatches < 10)
                  $display("pos mismatch: expected %h %h %h, got %h %h %h",
                           want.x, want.y, want.z, rsp_pos_x, rsp_pos_y, rsp_pos_z);
               mismatches++;
            end
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
   end

   initial begin
      int i;
      // n = 1 from reset: both ends reflected
      dir_rows = '{
         '{OP_WRITE, 0,    PT_A,    0,     0,      1'b0, PT_ZERO},
         '{OP_WRITE, 1,    PT_B,    0,     0,      1'b0, PT_ZERO},
         '{OP_EVAL,  0,    PT_ZERO, -1,    32768,  1'b1, PT_A},
         '{OP_EVAL,  0,    PT_ZERO, 1,     32768,  1'b1, PT_B},
         '{OP_EVAL,  0,    PT_ZERO, 0,     0,      1'b1, PT_A},
         '{OP_EVAL,  0,    PT_ZERO, 0,     65536,  1'b1, PT_B},
         '{OP_EVAL,  0,    PT_ZERO, 0,     131071, 1'b1, PT_B},
         '{OP_EVAL,  0,    PT_ZERO, -1024, 0,      1'b1, PT_A},
         '{OP_EVAL,  0,    PT_ZERO, 1023,  1,      1'b1, PT_B},
         '{OP_EVAL,  0,    PT_ZERO, 0,     1,      1'b0, PT_ZERO},
         '{OP_EVAL,  0,    PT_ZERO, 0,     65535,  1'b0, PT_ZERO},
         '{OP_EVAL,  0,    PT_ZERO, 0,     32768,  1'b0, PT_ZERO},
         '{OP_WRITE, 0,    PT_HI,   0,     0,      1'b0, PT_ZERO},
         '{OP_WRITE, 1,    PT_LO,   0,     0,      1'b0, PT_ZERO},
         '{OP_EVAL,  0,    PT_ZERO, 0,     16384,  1'b0, PT_ZERO},
         '{OP_EVAL,  0,    PT_ZERO, 0,     49152,  1'b0, PT_ZERO},
         '{OP_EVAL,  0,    PT_ZERO, 0,     65535,  1'b0, PT_ZERO},
         '{OP_WRITE, 1023, PT_LO,   0,     0,      1'b0, PT_ZERO},
         '{OP_WRITE, 2,    PT_HI,   0,     0,      1'b0, PT_ZERO},
         '{OP_WRITE, 0,    PT_C,    0,     0,      1'b0, PT_ZERO},
         '{OP_WRITE, 1,    PT_C,    0,     0,      1'b0, PT_ZERO},
         '{OP_EVAL,  0,    PT_ZERO, 0,     21845,  1'b1, PT_C}
      };
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      for (i = 0; i < DIR_ROWS; i++) send_word(dir_rows[i]);

      run_phase(0, 0, 0, 60);
      run_phase(MAX_POINTS - 1, 88, 0, 90);
      run_phase(5, 0, 88, 90);
      run_phase($urandom_range(2, 40), 10, 10, 110);
      run_phase(1, 0, 0, 60);

      req_valid <= 1'b0;
      while (due_points.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
